[hw/rtl/dau_pkg.sv]
`timescale 1ns / 1ps
package dau_pkg;

  // input geometry
  localparam int COORD_BITS    = 20;
  localparam int NCOORD        = 12;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;

  // derived widths of the exact integer datapath
  localparam int BW    = COORD_BITS + 1;     // bond vector component
  localparam int PW    = 2 * BW;             // product of two components
  localparam int NW    = PW + 1;             // normal component
  localparam int BBW   = PW + 2;             // |b2|^2
  localparam int NLO   = NW / 2;             // unsigned low slice of a normal
  localparam int NHI   = NW - NLO;           // signed high slice of a normal
  localparam int PLW   = NW + NLO + 1;
  localparam int PHW   = NW + NHI;
  localparam int FW    = 2 * NW;
  localparam int BNW   = BW + NW;
  localparam int DW1   = BNW + 2;            // b1 . n2
  localparam int DW2   = FW + 2;             // n . n
  localparam int SQRT_PAD = 32;              // |b2| is taken as sqrt(|b2|^2 * 2^32)
  localparam int SQW   = BBW + SQRT_PAD;
  localparam int RW    = SQW / 2;            // root width
  localparam int REMW  = RW + 3;
  localparam int RLO   = RW / 2;
  localparam int RHI   = RW - RLO;
  localparam int PLOW  = DW1 + RLO + 1;
  localparam int PHIW  = DW1 + RHI + 1;
  localparam int X_SHIFT = 16;
  localparam int VW    = ((DW1 + RW > DW2 + X_SHIFT) ? DW1 + RW : DW2 + X_SHIFT) + 1;
  localparam int NORM_BITS  = 29;
  localparam int NORM_STEPS = $clog2(VW);
  localparam int CW    = 34;                 // CORDIC datapath
  localparam int ZW    = 32;                 // binary angle, 2^31 = pi
  localparam int OUTW  = 16;
  localparam int Q14_SHIFT = 16;

  // configuration
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 64;
  localparam int BOND_MIN_BITS = 32;
  localparam int NORM_MIN_BITS = 63;
  localparam int BCMPW = (BBW > BOND_MIN_BITS) ? BBW : BOND_MIN_BITS;
  localparam int NCMPW = (DW2 > NORM_MIN_BITS) ? DW2 : NORM_MIN_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BOND_LEN_SQ_MIN   = 1'b0,
    REG_NORMAL_LEN_SQ_MIN = 1'b1
  } cfg_reg_t;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [ZW-1:0] Z_QUARTER       = 32'h4000_0000;
  localparam logic [ZW-1:0] Z_THREE_QUARTER = 32'hC000_0000;
  localparam logic [ZW-1:0] Z_ROUND         = 32'h0000_8000;
  localparam logic signed [CW-1:0] HALF_PI   = CW'(64'sd1073741824);
  localparam logic signed [CW-1:0] PI_BIN    = CW'(64'sd2147483648);
  localparam logic signed [CW-1:0] CORDIC_X0 = CW'(64'sd652032874);
  localparam logic signed [CW-1:0] Q14_ROUND = CW'(64'sd32768);
  localparam logic signed [CW-1:0] Q14_ONE   = CW'(64'sd16384);

  typedef struct packed {
    logic                degen;
    logic [BBW-1:0]      bb;
    logic [DW1-1:0]      d1;    // b1 . n2, two's complement
    logic [DW2-1:0]      d2;    // n1 . n2, two's complement
  } dau_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dau_qstat_t;

  typedef struct packed {
    logic [BOND_MIN_BITS-1:0] bond_min;
    logic [NORM_MIN_BITS-1:0] norm_min;
  } dau_cfg_t;

  function automatic logic [ZW-1:0] atan_entry(input int unsigned i);
    logic [ZW-1:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/dau_front.sv]
`timescale 1ns / 1ps
module dau_front (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          pnt_valid,
  output logic                                          pnt_stall,
  input  logic [dau_pkg::NCOORD-1:0][dau_pkg::COORD_BITS-1:0] pts,
  input  dau_pkg::dau_cfg_t                             cfg,
  input  logic                                          push_ok,
  output logic                                          push,
  output dau_pkg::dau_item_t                            item
);
  import dau_pkg::*;

  logic en;
  logic v1, v2, v3, v4, v5, v6, v7, v8;

  logic signed [COORD_BITS-1:0] p [NCOORD];
  logic signed [BW-1:0]  b1 [3], b2 [3], b3 [3];
  logic signed [PW-1:0]  c1a [3], c1b [3], c2a [3], c2b [3], sq [3];
  logic signed [BW-1:0]  b1_3 [3], b1_4 [3];
  logic signed [NW-1:0]  n1 [3], n2 [3];
  logic [BBW-1:0]        bb4, bb5, bb6, bb7;
  logic signed [PLW-1:0] nn1_lo [3], nn2_lo [3], n12_lo [3];
  logic signed [PHW-1:0] nn1_hi [3], nn2_hi [3], n12_hi [3];
  logic signed [BNW-1:0] bn [3];
  logic signed [FW-1:0]  nn1_f [3], nn2_f [3], n12_f [3];
  logic signed [DW1-1:0] d1_6, d1_7;
  logic signed [DW2-1:0] s_nn1, s_nn2, s_n12;

  assign en        = !v8 || push_ok;
  assign push      = v8 && push_ok;
  assign pnt_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0;
    end else if (en) begin
      v1 <= pnt_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6; v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NCOORD; k++) begin
        p[k] <= pts[k];
      end
      // bond vectors
      for (int i = 0; i < 3; i++) begin
        b1[i] <= BW'(p[3 + i]) - BW'(p[i]);
        b2[i] <= BW'(p[6 + i]) - BW'(p[3 + i]);
        b3[i] <= BW'(p[9 + i]) - BW'(p[6 + i]);
      end
      // cross product terms
      c1a[0] <= PW'(b1[1]) * PW'(b2[2]);  c1b[0] <= PW'(b1[2]) * PW'(b2[1]);
      c1a[1] <= PW'(b1[2]) * PW'(b2[0]);  c1b[1] <= PW'(b1[0]) * PW'(b2[2]);
      c1a[2] <= PW'(b1[0]) * PW'(b2[1]);  c1b[2] <= PW'(b1[1]) * PW'(b2[0]);
      c2a[0] <= PW'(b2[1]) * PW'(b3[2]);  c2b[0] <= PW'(b2[2]) * PW'(b3[1]);
      c2a[1] <= PW'(b2[2]) * PW'(b3[0]);  c2b[1] <= PW'(b2[0]) * PW'(b3[2]);
      c2a[2] <= PW'(b2[0]) * PW'(b3[1]);  c2b[2] <= PW'(b2[1]) * PW'(b3[0]);
      for (int i = 0; i < 3; i++) begin
        sq[i]   <= PW'(b2[i]) * PW'(b2[i]);
        b1_3[i] <= b1[i];
      end
      // normals
      for (int i = 0; i < 3; i++) begin
        n1[i]   <= NW'(c1a[i]) - NW'(c1b[i]);
        n2[i]   <= NW'(c2a[i]) - NW'(c2b[i]);
        b1_4[i] <= b1_3[i];
      end
      bb4 <= BBW'(sq[0]) + BBW'(sq[1]) + BBW'(sq[2]);
      // wide products split on the second operand
      for (int i = 0; i < 3; i++) begin
        nn1_lo[i] <= PLW'(n1[i]) * PLW'($signed({1'b0, n1[i][NLO-1:0]}));
        nn1_hi[i] <= PHW'(n1[i]) * PHW'($signed(n1[i][NW-1:NLO]));
        nn2_lo[i] <= PLW'(n2[i]) * PLW'($signed({1'b0, n2[i][NLO-1:0]}));
        nn2_hi[i] <= PHW'(n2[i]) * PHW'($signed(n2[i][NW-1:NLO]));
        n12_lo[i] <= PLW'(n1[i]) * PLW'($signed({1'b0, n2[i][NLO-1:0]}));
        n12_hi[i] <= PHW'(n1[i]) * PHW'($signed(n2[i][NW-1:NLO]));
        bn[i]     <= BNW'(b1_4[i]) * BNW'(n2[i]);
      end
      bb5 <= bb4;
      for (int i = 0; i < 3; i++) begin
        nn1_f[i] <= (FW'(nn1_hi[i]) <<< NLO) + FW'(nn1_lo[i]);
        nn2_f[i] <= (FW'(nn2_hi[i]) <<< NLO) + FW'(nn2_lo[i]);
        n12_f[i] <= (FW'(n12_hi[i]) <<< NLO) + FW'(n12_lo[i]);
      end
      d1_6 <= DW1'(bn[0]) + DW1'(bn[1]) + DW1'(bn[2]);
      bb6  <= bb5;
      s_nn1 <= DW2'(nn1_f[0]) + DW2'(nn1_f[1]) + DW2'(nn1_f[2]);
      s_nn2 <= DW2'(nn2_f[0]) + DW2'(nn2_f[1]) + DW2'(nn2_f[2]);
      s_n12 <= DW2'(n12_f[0]) + DW2'(n12_f[1]) + DW2'(n12_f[2]);
      d1_7  <= d1_6;
      bb7   <= bb6;
      // degenerate check; squared lengths are never negative
      item.degen <= (BCMPW'(bb7) <= BCMPW'(cfg.bond_min)) ||
                    (NCMPW'($unsigned(s_nn1)) <= NCMPW'(cfg.norm_min)) ||
                    (NCMPW'($unsigned(s_nn2)) <= NCMPW'(cfg.norm_min));
      item.bb <= bb7;
      item.d1 <= d1_7;
      item.d2 <= s_n12;
    end
  end

endmodule

[hw/rtl/dau_queue.sv]
`timescale 1ns / 1ps
module dau_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dau_pkg::dau_item_t  wr_item,
  input  logic                pop,
  output dau_pkg::dau_item_t  head,
  output dau_pkg::dau_qstat_t stat
);
  import dau_pkg::*;

  dau_item_t      mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;

  assign head       = mem[rd_ptr];
  assign stat.full  = (count == (QAW+1)'(QDEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  a_push_full: assert property (@(posedge clk) disable iff (rst)
    (push && stat.full) |-> pop) else $error("queue overrun");
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty) else $error("queue underrun");
  a_cnt_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1)) else $error("count lost a push");
  a_cnt_dn: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1)) else $error("count lost a pop");

endmodule

[hw/rtl/dau_back.sv]
`timescale 1ns / 1ps
module dau_back (
  input  logic                              clk,
  input  logic                              rst,
  input  dau_pkg::dau_item_t                head,
  input  dau_pkg::dau_qstat_t               qstat,
  output logic                              pop,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic signed [dau_pkg::OUTW-1:0]   angle,
  output logic signed [dau_pkg::OUTW-1:0]   sine,
  output logic signed [dau_pkg::OUTW-1:0]   cosine,
  output logic                              valid_res
);
  import dau_pkg::*;

  function automatic logic signed [OUTW-1:0] to_q14(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (v + Q14_ROUND) >>> Q14_SHIFT;
    if (r > Q14_ONE) begin
      r = Q14_ONE;
    end else if (r < -Q14_ONE) begin
      r = -Q14_ONE;
    end
    return OUTW'(r);
  endfunction

  logic en;
  assign en  = !(res_valid && res_stall);
  assign pop = en && !qstat.empty;

  // ---------------- square root, one result bit per stage
  logic            sq_v    [RW+1];
  logic [REMW-1:0] sq_rem  [RW+1];
  logic [RW-1:0]   sq_root [RW+1];
  dau_item_t       sq_it   [RW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= !qstat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_it[0]   <= head;
    end
  end

  for (genvar s = 0; s < RW; s++) begin : g_sqrt
    localparam int K = RW - 1 - s;
    logic [SQW-1:0]  nval;
    logic [REMW-1:0] rs, trial;
    logic            ge;
    assign nval  = {sq_it[s].bb, {SQRT_PAD{1'b0}}};
    assign rs    = {sq_rem[s][REMW-3:0], nval[2*K+1:2*K]};
    assign trial = REMW'({sq_root[s], 2'b01});
    assign ge    = (rs >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[s+1] <= 1'b0;
      end else if (en) begin
        sq_v[s+1] <= sq_v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[s+1]  <= ge ? rs - trial : rs;
        sq_root[s+1] <= {sq_root[s][RW-2:0], ge};
        sq_it[s+1]   <= sq_it[s];
      end
    end
  end

  // ---------------- Y = (b1.n2)*root, X = (n1.n2)*2^16, then magnitudes
  logic                  m1_v, m2_v;
  logic                  m1_d, m2_d;
  logic signed [PLOW-1:0] m1_plo;
  logic signed [PHIW-1:0] m1_phi;
  logic [DW2-1:0]        m1_d2;
  logic signed [VW-1:0]  m2_x, m2_y;
  logic [VW-1:0]         ax, ay;

  assign ax = m2_x[VW-1] ? VW'(-m2_x) : VW'(m2_x);
  assign ay = m2_y[VW-1] ? VW'(-m2_y) : VW'(m2_y);

  logic                  nm_v [NORM_STEPS+1];
  logic                  nm_d [NORM_STEPS+1];
  logic [VW-1:0]         nm_m [NORM_STEPS+1];
  logic signed [VW-1:0]  nm_x [NORM_STEPS+1];
  logic signed [VW-1:0]  nm_y [NORM_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v    <= 1'b0;
      m2_v    <= 1'b0;
      nm_v[0] <= 1'b0;
    end else if (en) begin
      m1_v    <= sq_v[RW];
      m2_v    <= m1_v;
      nm_v[0] <= m2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_plo  <= PLOW'($signed(sq_it[RW].d1)) * PLOW'($signed({1'b0, sq_root[RW][RLO-1:0]}));
      m1_phi  <= PHIW'($signed(sq_it[RW].d1)) * PHIW'($signed({1'b0, sq_root[RW][RW-1:RLO]}));
      m1_d2   <= sq_it[RW].d2;
      m1_d    <= sq_it[RW].degen;
      m2_y    <= (VW'(m1_phi) <<< RLO) + VW'(m1_plo);
      m2_x    <= VW'($signed(m1_d2)) <<< X_SHIFT;
      m2_d    <= m1_d;
      nm_m[0] <= ax | ay;
      nm_x[0] <= m2_x;
      nm_y[0] <= m2_y;
      nm_d[0] <= m2_d;
    end
  end

  // ---------------- shift both down until magnitudes fit NORM_BITS
  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int S = 1 << (NORM_STEPS - 1 - j);
    logic hit;
    if (NORM_BITS - 1 + S < VW) begin : g_cmp
      assign hit = |(nm_m[j] >> (NORM_BITS - 1 + S));
    end else begin : g_none
      assign hit = 1'b0;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        nm_v[j+1] <= 1'b0;
      end else if (en) begin
        nm_v[j+1] <= nm_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nm_m[j+1] <= hit ? (nm_m[j] >> S) : nm_m[j];
        nm_x[j+1] <= hit ? (nm_x[j] >>> S) : nm_x[j];
        nm_y[j+1] <= hit ? (nm_y[j] >>> S) : nm_y[j];
        nm_d[j+1] <= nm_d[j];
      end
    end
  end

  // ---------------- vectoring CORDIC with quadrant pre-rotation
  logic                 cv_v [CORDIC_STAGES+1];
  logic                 cv_d [CORDIC_STAGES+1];
  logic signed [CW-1:0] cv_x [CORDIC_STAGES+1];
  logic signed [CW-1:0] cv_y [CORDIC_STAGES+1];
  logic [ZW-1:0]        cv_z [CORDIC_STAGES+1];
  logic signed [CW-1:0] xs, ys, vx0, vy0;
  logic [ZW-1:0]        vz0;

  assign xs = CW'($signed(nm_x[NORM_STEPS][NORM_BITS:0]));
  assign ys = CW'($signed(nm_y[NORM_STEPS][NORM_BITS:0]));

  always_comb begin
    vx0 = xs;
    vy0 = ys;
    vz0 = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        vx0 = ys;
        vy0 = -xs;
        vz0 = Z_QUARTER;
      end else begin
        vx0 = -ys;
        vy0 = xs;
        vz0 = Z_THREE_QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv_v[0] <= 1'b0;
    end else if (en) begin
      cv_v[0] <= nm_v[NORM_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cv_x[0] <= vx0;
      cv_y[0] <= vy0;
      cv_z[0] <= vz0;
      cv_d[0] <= nm_d[NORM_STEPS];
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    localparam logic [ZW-1:0] ATAN = atan_entry(i);
    logic signed [CW-1:0] dx, dy;
    logic                 up;
    assign dx = cv_y[i] >>> i;
    assign dy = cv_x[i] >>> i;
    assign up = (cv_y[i] > 0);

    always_ff @(posedge clk) begin
      if (rst) begin
        cv_v[i+1] <= 1'b0;
      end else if (en) begin
        cv_v[i+1] <= cv_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cv_x[i+1] <= up ? cv_x[i] + dx : cv_x[i] - dx;
        cv_y[i+1] <= up ? cv_y[i] - dy : cv_y[i] + dy;
        cv_z[i+1] <= up ? cv_z[i] + ATAN : cv_z[i] - ATAN;
        cv_d[i+1] <= cv_d[i];
      end
    end
  end

  // ---------------- rotation CORDIC for sine and cosine
  logic                 rt_v   [CORDIC_STAGES+1];
  logic                 rt_d   [CORDIC_STAGES+1];
  logic                 rt_neg [CORDIC_STAGES+1];
  logic signed [CW-1:0] rt_x   [CORDIC_STAGES+1];
  logic signed [CW-1:0] rt_y   [CORDIC_STAGES+1];
  logic signed [CW-1:0] rt_z   [CORDIC_STAGES+1];
  logic [ZW-1:0]        rt_ang [CORDIC_STAGES+1];
  logic signed [CW-1:0] wz, fz;
  logic                 fneg;

  assign wz = CW'($signed(cv_z[CORDIC_STAGES]));

  // fold into [-pi/2, pi/2]; the sign flip is undone at the output
  always_comb begin
    fz   = wz;
    fneg = 1'b0;
    if (wz > HALF_PI) begin
      fz   = wz - PI_BIN;
      fneg = 1'b1;
    end else if (wz < -HALF_PI) begin
      fz   = wz + PI_BIN;
      fneg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_v[0] <= 1'b0;
    end else if (en) begin
      rt_v[0] <= cv_v[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt_x[0]   <= CORDIC_X0;
      rt_y[0]   <= '0;
      rt_z[0]   <= fz;
      rt_neg[0] <= fneg;
      rt_ang[0] <= cv_z[CORDIC_STAGES];
      rt_d[0]   <= cv_d[CORDIC_STAGES];
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    localparam logic signed [CW-1:0] ATAN = $signed(CW'(atan_entry(i)));
    logic signed [CW-1:0] dx, dy;
    logic                 pos;
    assign dx  = rt_y[i] >>> i;
    assign dy  = rt_x[i] >>> i;
    assign pos = (rt_z[i] >= 0);

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_v[i+1] <= 1'b0;
      end else if (en) begin
        rt_v[i+1] <= rt_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt_x[i+1]   <= pos ? rt_x[i] - dx : rt_x[i] + dx;
        rt_y[i+1]   <= pos ? rt_y[i] + dy : rt_y[i] - dy;
        rt_z[i+1]   <= pos ? rt_z[i] - ATAN : rt_z[i] + ATAN;
        rt_neg[i+1] <= rt_neg[i];
        rt_ang[i+1] <= rt_ang[i];
        rt_d[i+1]   <= rt_d[i];
      end
    end
  end

  // ---------------- output register
  logic signed [OUTW-1:0] qs, qc;
  logic [ZW-1:0]          zr;

  assign qs = to_q14(rt_y[CORDIC_STAGES]);
  assign qc = to_q14(rt_x[CORDIC_STAGES]);
  assign zr = rt_ang[CORDIC_STAGES] + Z_ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= rt_v[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (rt_d[CORDIC_STAGES]) begin
        angle     <= '0;
        sine      <= '0;
        cosine    <= '0;
        valid_res <= 1'b0;
      end else begin
        angle     <= $signed(zr[ZW-1:ZW-OUTW]);
        sine      <= rt_neg[CORDIC_STAGES] ? -qs : qs;
        cosine    <= rt_neg[CORDIC_STAGES] ? -qc : qc;
        valid_res <= 1'b1;
      end
    end
  end

endmodule

[hw/rtl/dihedral_angle_unit.sv]
`timescale 1ns / 1ps
// Pipeline: 8 front stages, the queue, then the back stages (38 root steps, two
//   16-stage CORDICs); every stage is a pipeline register.
// Throughput: one transaction per cycle while the result output is not stalled.
// Reset (rst, synchronous): clears all stage valids, the queue and both threshold
//   registers; no other state, no clearing pass.
module dihedral_angle_unit (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     pnt_valid,
  output logic                                     pnt_stall,
  input  logic signed [dau_pkg::COORD_BITS-1:0]    p0_x,
  input  logic signed [dau_pkg::COORD_BITS-1:0]    p0_y,
  input  logic signed [dau_pkg::COORD_BITS-1:0]    p0_z,
  input  logic signed [dau_pkg::COORD_BITS-1:0]    p1_x,
  input  logic signed [dau_pkg::COORD_BITS-1:0]    p1_y,
  input  logic signed [dau_pkg::COORD_BITS-1:0]    p1_z,
  input  logic signed [dau_pkg::COORD_BITS-1:0]    p2_x,
  input  logic signed [dau_pkg::COORD_BITS-1:0]    p2_y,
  input  logic signed [dau_pkg::COORD_BITS-1:0]    p2_z,
  input  logic signed [dau_pkg::COORD_BITS-1:0]    p3_x,
  input  logic signed [dau_pkg::COORD_BITS-1:0]    p3_y,
  input  logic signed [dau_pkg::COORD_BITS-1:0]    p3_z,
  output logic                                     res_valid,
  input  logic                                     res_stall,
  output logic signed [dau_pkg::OUTW-1:0]          angle,
  output logic signed [dau_pkg::OUTW-1:0]          sine,
  output logic signed [dau_pkg::OUTW-1:0]          cosine,
  output logic                                     valid_res,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [dau_pkg::CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [dau_pkg::CFG_DATA_BITS-1:0]        cfg_data
);
  import dau_pkg::*;

  dau_cfg_t                         cfg;
  logic [NCOORD-1:0][COORD_BITS-1:0] pts;
  logic                             push, push_ok, pop;
  dau_item_t                        f_item, q_head;
  dau_qstat_t                       qstat;

  assign cfg_ready = 1'b1;
  assign pts = {p3_z, p3_y, p3_x, p2_z, p2_y, p2_x, p1_z, p1_y, p1_x, p0_z, p0_y, p0_x};
  assign push_ok = !qstat.full || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BOND_LEN_SQ_MIN:   cfg.bond_min <= cfg_data[BOND_MIN_BITS-1:0];
        REG_NORMAL_LEN_SQ_MIN: cfg.norm_min <= cfg_data[NORM_MIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  dau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pnt_valid (pnt_valid),
    .pnt_stall (pnt_stall),
    .pts       (pts),
    .cfg       (cfg),
    .push_ok   (push_ok),
    .push      (push),
    .item      (f_item)
  );

  dau_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (f_item),
    .pop     (pop),
    .head    (q_head),
    .stat    (qstat)
  );

  dau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .qstat     (qstat),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .angle     (angle),
    .sine      (sine),
    .cosine    (cosine),
    .valid_res (valid_res)
  );

endmodule
